### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both sample on aclk and are
// disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A condition that must hold whenever a trigger is seen.
`define ASSERT_IMPLIES(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |-> (cond)) else $error(msg);

`endif

### rtl/lse_pkg.sv
`timescale 1ns / 1ps

package lse_pkg;

    localparam int VALUE_W = 32;
    localparam int DELTA_W = 33;
    localparam int STEPS_W = 24;
    localparam int STATUS_W = 2;

    // One quotient bit is produced per divider iteration.
    localparam int DIV_STEPS = DELTA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_APPEND = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_SAMPLE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_HOLD     = 2'd3;

    typedef struct packed {
        logic                      opcode;
        logic signed [VALUE_W-1:0] start_value;
        logic signed [VALUE_W-1:0] end_value;
        logic [STEPS_W-1:0]        step_count;
    } lse_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic [STATUS_W-1:0]       status;
        logic                      more_pending;
    } lse_out_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] start_value;
        logic signed [VALUE_W-1:0] end_value;
        logic [STEPS_W-1:0]        step_count;
    } lse_seg_t;

endpackage

### rtl/linear_segment_envelope_core.sv
// Append, ramp step and hold items: IDLE takes the input, then EXEC registers the result
// once the output register is free. A segment pop runs EXEC (the head-entry read lands in
// rd_data_reg), READ (divider setup), DIV (radix-2 divider forming the 33-bit per-segment
// delta, one quotient bit per iteration) and FINISH (one commit once the output is free).
// A new item is taken only back in IDLE, after the last result; m_ready can hold that back.
// Reset (aresetn low, synchronous) clears pointers, count, value, delta, step counter and
// the handshake; the segment memory keeps its contents and holds nothing valid after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module linear_segment_envelope_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lse_pkg::lse_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lse_pkg::lse_out_t m_data
);
    import lse_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    lse_in_t    item_reg, item_next;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic signed [DELTA_W-1:0] delta_reg, delta_next;
    logic [STEPS_W-1:0]        steps_reg, steps_next;

    logic     m_valid_reg, m_valid_next;
    lse_out_t m_data_reg, m_data_next;

    // Segment memory, one entry per queued segment.
    lse_seg_t seg_mem [QUEUE_DEPTH];
    lse_seg_t rd_data_reg;
    logic     mem_we;
    lse_seg_t mem_wdata;

    // Divider and pending-segment state.
    logic [STEPS_W-1:0]   div_rem_reg, div_rem_next;
    logic [DELTA_W-1:0]   div_quo_reg, div_quo_next;
    logic [STEPS_W-1:0]   div_den_reg, div_den_next;
    logic                 div_neg_reg, div_neg_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic signed [VALUE_W-1:0] seg_start_reg, seg_start_next;
    logic [STEPS_W-1:0]        seg_steps_m1_reg, seg_steps_m1_next;

    logic                      out_free;
    logic                      queue_full;
    logic signed [VALUE_W+1:0] ramp_sum;
    logic signed [VALUE_W-1:0] ramp_value;
    logic [STEPS_W-1:0]        rd_steps;
    logic signed [DELTA_W-1:0] rd_diff;
    logic [STEPS_W:0]          div_trial;
    logic [CNT_W-1:0]          count_dec;

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;
    assign out_free   = !m_valid_reg || m_ready;
    assign queue_full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign count_dec  = count_reg - CNT_W'(1);

    // The ramp saturates to the 32-bit signed range.
    always_comb begin
        ramp_sum = {{2{value_reg[VALUE_W-1]}}, value_reg} + {delta_reg[DELTA_W-1], delta_reg};
        if (ramp_sum[VALUE_W+1:VALUE_W-1] == 3'b000 ||
            ramp_sum[VALUE_W+1:VALUE_W-1] == 3'b111) begin
            ramp_value = ramp_sum[VALUE_W-1:0];
        end else if (ramp_sum[VALUE_W+1]) begin
            ramp_value = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            ramp_value = {1'b0, {(VALUE_W-1){1'b1}}};
        end
    end

    assign rd_steps  = (rd_data_reg.step_count == '0) ? STEPS_W'(1) : rd_data_reg.step_count;
    assign rd_diff   = {rd_data_reg.end_value[VALUE_W-1], rd_data_reg.end_value}
                     - {rd_data_reg.start_value[VALUE_W-1], rd_data_reg.start_value};
    assign div_trial = {div_rem_reg, div_quo_reg[DELTA_W-1]};

    always_comb begin
        state_next        = state_reg;
        item_next         = item_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        value_next        = value_reg;
        delta_next        = delta_reg;
        steps_next        = steps_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;
        mem_we            = 1'b0;
        mem_wdata         = '{start_value: item_reg.start_value,
                              end_value:   item_reg.end_value,
                              step_count:  item_reg.step_count};
        div_rem_next      = div_rem_reg;
        div_quo_next      = div_quo_reg;
        div_den_next      = div_den_reg;
        div_neg_next      = div_neg_reg;
        div_cnt_next      = div_cnt_reg;
        seg_start_next    = seg_start_reg;
        seg_steps_m1_next = seg_steps_m1_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (item_reg.opcode == OP_SAMPLE && steps_reg == '0 && count_reg != '0) begin
                    // The memory read of the head entry lands in rd_data_reg this cycle.
                    state_next = ST_READ;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (item_reg.opcode == OP_APPEND) begin
                        m_data_next.sample_value = value_reg;
                        if (queue_full) begin
                            m_data_next.status       = STATUS_DROPPED;
                            m_data_next.more_pending = 1'b1;
                        end else begin
                            mem_we     = 1'b1;
                            tail_next  = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                         '0 : tail_reg + PTR_W'(1);
                            count_next = count_reg + CNT_W'(1);
                            m_data_next.status       = STATUS_ACCEPTED;
                            m_data_next.more_pending = 1'b1;
                        end
                    end else if (steps_reg != '0) begin
                        steps_next = steps_reg - STEPS_W'(1);
                        value_next = ramp_value;
                        m_data_next.sample_value = ramp_value;
                        m_data_next.status       = STATUS_SAMPLE;
                        m_data_next.more_pending = (steps_reg != STEPS_W'(1)) ||
                                                   (count_reg != '0);
                    end else begin
                        m_data_next.sample_value = value_reg;
                        m_data_next.status       = STATUS_HOLD;
                        m_data_next.more_pending = 1'b0;
                    end
                end
            end
            ST_READ: begin
                // Divide the magnitude, then restore the sign: truncation toward zero.
                div_neg_next      = rd_diff[DELTA_W-1];
                div_quo_next      = rd_diff[DELTA_W-1] ? (~rd_diff + DELTA_W'(1)) : rd_diff;
                div_rem_next      = '0;
                div_den_next      = rd_steps;
                div_cnt_next      = DIV_CNT_W'(DIV_STEPS - 1);
                seg_start_next    = rd_data_reg.start_value;
                seg_steps_m1_next = rd_steps - STEPS_W'(1);
                state_next        = ST_DIV;
            end
            ST_DIV: begin
                if (div_trial >= {1'b0, div_den_reg}) begin
                    div_rem_next = STEPS_W'(div_trial - {1'b0, div_den_reg});
                    div_quo_next = {div_quo_reg[DELTA_W-2:0], 1'b1};
                end else begin
                    div_rem_next = div_trial[STEPS_W-1:0];
                    div_quo_next = {div_quo_reg[DELTA_W-2:0], 1'b0};
                end
                if (div_cnt_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    value_next  = seg_start_reg;
                    delta_next  = div_neg_reg ? -$signed(div_quo_reg) : $signed(div_quo_reg);
                    steps_next  = seg_steps_m1_reg;
                    head_next   = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                  '0 : head_reg + PTR_W'(1);
                    count_next  = count_dec;
                    m_valid_next = 1'b1;
                    m_data_next.sample_value = seg_start_reg;
                    m_data_next.status       = STATUS_SAMPLE;
                    m_data_next.more_pending = (seg_steps_m1_reg != '0) || (count_dec != '0);
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            seg_mem[tail_reg] <= mem_wdata;
        end
        rd_data_reg <= seg_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            value_reg   <= '0;
            delta_reg   <= '0;
            steps_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            value_reg   <= value_next;
            delta_reg   <= delta_next;
            steps_reg   <= steps_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg         <= item_next;
        m_data_reg       <= m_data_next;
        div_rem_reg      <= div_rem_next;
        div_quo_reg      <= div_quo_next;
        div_den_reg      <= div_den_next;
        div_neg_reg      <= div_neg_next;
        div_cnt_reg      <= div_cnt_next;
        seg_start_reg    <= seg_start_next;
        seg_steps_m1_reg <= seg_steps_m1_next;
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
    `ASSERT_IMPLIES(a_ptr_count, head_reg == tail_reg,
        count_reg == '0 || count_reg == CNT_W'(QUEUE_DEPTH), "pointers disagree with count")
    `ASSERT_IMPLIES(a_finish_entry, state_reg == ST_FINISH,
        $past(state_reg) == ST_DIV || $past(state_reg) == ST_FINISH,
        "commit reached without division")
    `ASSERT_IMPLIES(a_hold_idle, m_valid_reg && m_data_reg.status == STATUS_HOLD,
        !m_data_reg.more_pending, "hold result reports pending work")

endmodule
